// ===== rtl/bmfs_pkg.sv =====
// Shared constants, codes and transaction types of the block-mapped file store.
package bmfs_pkg;

  localparam int FILE_SLOTS      = 32;
  localparam int POOL_BLOCKS     = 256;
  localparam int BLOCK_BYTES     = 512;
  localparam int BLOCKS_PER_FILE = 8;

  localparam int SLOT_W    = $clog2(FILE_SLOTS);
  localparam int BLK_W     = $clog2(POOL_BLOCKS);
  localparam int WITHIN_W  = $clog2(BLOCK_BYTES);
  localparam int ENTRY_W   = $clog2(BLOCKS_PER_FILE);
  localparam int MAP_W     = SLOT_W + ENTRY_W;
  localparam int MAP_DEPTH = FILE_SLOTS * BLOCKS_PER_FILE;
  localparam int STORE_W   = BLK_W + WITHIN_W;
  localparam int STORE_DEPTH = POOL_BLOCKS * BLOCK_BYTES;
  localparam int OP_W      = 3;
  localparam int OFF_W     = 16;
  localparam int DATA_W    = 8;
  localparam int STATUS_W  = 3;
  localparam int LEN_W     = 13;
  localparam int ENTRYF_W  = OFF_W - WITHIN_W;

  localparam logic [OP_W-1:0] OPC_CREATE = 3'd0;
  localparam logic [OP_W-1:0] OPC_WRITE  = 3'd1;
  localparam logic [OP_W-1:0] OPC_READ   = 3'd2;
  localparam logic [OP_W-1:0] OPC_TRUNC  = 3'd3;
  localparam logic [OP_W-1:0] OPC_DELETE = 3'd4;
  localparam logic [OP_W-1:0] OPC_QUERY  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BADFILE  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EOF      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNMAPPED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOSPACE  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOSLOT   = 3'd5;

  typedef enum logic [2:0] {
    CMD_CREATE,
    CMD_WRITE,
    CMD_READ,
    CMD_TRUNC,
    CMD_DELETE,
    CMD_QUERY,
    CMD_BAD
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e            kind;
    logic [SLOT_W-1:0]    file_index;
    logic [OFF_W-1:0]     offset;
    logic [DATA_W-1:0]    data;
    logic [ENTRY_W-1:0]   entry;
    logic [WITHIN_W-1:0]  byte_sel;
    logic                 entry_over;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [DATA_W-1:0]   rbyte;
    logic [SLOT_W-1:0]   slot;
    logic [LEN_W-1:0]    len;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_MAPUSE,
    S_RDWAIT,
    S_SLOTSCAN,
    S_BLKSCAN,
    S_CLEAR,
    S_WRBYTE,
    S_DROP,
    S_FREE
  } back_state_e;

endpackage

// ===== rtl/bmfs_front.sv =====
// Front end: accepts transactions, decodes them and queues them for the back end.
module bmfs_front import bmfs_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [OP_W-1:0]     opcode_i,
  input  logic [SLOT_W-1:0]   file_index_i,
  input  logic [OFF_W-1:0]    offset_i,
  input  logic [DATA_W-1:0]   data_byte_i,
  output cmd_t                cmd_o,
  output logic                cmd_valid_o,
  input  logic                cmd_pop_i
);

  cmd_t       cls;
  cmd_t       q_mem [2];
  logic       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  always_comb begin
    cls.file_index = file_index_i;
    cls.offset     = offset_i;
    cls.data       = data_byte_i;
    cls.byte_sel   = offset_i[WITHIN_W-1:0];
    cls.entry      = offset_i[WITHIN_W +: ENTRY_W];
    cls.entry_over = offset_i[OFF_W-1:WITHIN_W] >= ENTRYF_W'(BLOCKS_PER_FILE);
    unique case (opcode_i)
      OPC_CREATE: cls.kind = CMD_CREATE;
      OPC_WRITE:  cls.kind = CMD_WRITE;
      OPC_READ:   cls.kind = CMD_READ;
      OPC_TRUNC:  cls.kind = CMD_TRUNC;
      OPC_DELETE: cls.kind = CMD_DELETE;
      OPC_QUERY:  cls.kind = CMD_QUERY;
      default:    cls.kind = CMD_BAD;
    endcase
  end

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rd_ptr_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ===== rtl/bmfs_back.sv =====
// Back end: file tables, block allocator, byte store and the result queue.
module bmfs_back import bmfs_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cmd_t  cmd_i,
  input  logic  cmd_valid_i,
  output logic  cmd_pop_o,
  output res_t  res_o,
  output logic  empty,
  input  logic  pop
);

  back_state_e state_q, state_d;
  cmd_t        cmd_q, cmd_d;
  logic [SLOT_W-1:0]   slot_q, slot_d;
  logic [BLK_W-1:0]    blk_q, blk_d;
  logic [WITHIN_W-1:0] clr_q, clr_d;
  logic [ENTRY_W-1:0]  k_q, k_d;

  logic [FILE_SLOTS-1:0]  in_use_q;
  logic [LEN_W-1:0]       size_q [FILE_SLOTS];
  logic [MAP_DEPTH-1:0]   mv_q;
  logic [POOL_BLOCKS-1:0] busy_q;

  logic [BLK_W-1:0]   map_mem [MAP_DEPTH];
  logic [BLK_W-1:0]   map_rdata_q;
  logic               map_rzero_q;
  logic [BLK_W-1:0]   map_blk;
  logic               map_we;
  logic [MAP_W-1:0]   map_waddr, map_raddr;

  logic [DATA_W-1:0]  store_mem [STORE_DEPTH];
  logic [DATA_W-1:0]  store_rdata_q;
  logic               store_we;
  logic [STORE_W-1:0] store_waddr, store_raddr;
  logic [DATA_W-1:0]  store_wdata;

  logic               in_use_set, in_use_clr;
  logic [SLOT_W-1:0]  in_use_idx;
  logic               size_we;
  logic [SLOT_W-1:0]  size_idx;
  logic [LEN_W-1:0]   size_wdata;
  logic               busy_set, busy_clr;
  logic [BLK_W-1:0]   busy_idx;
  logic               mv_set, mv_clr;
  logic [MAP_W-1:0]   mv_idx;

  logic [LEN_W-1:0]   cur_size, off_len, new_len;
  logic [MAP_W-1:0]   m_idx, k_idx, tgt_idx;
  logic               res_push;
  res_t               res_d;

  res_t       rq_mem [2];
  logic       rq_wr_q, rq_rd_q;
  logic [1:0] rq_cnt_q;
  logic       rq_pop;

  // Map entry zero belongs to the reserved slot and always names block zero.
  assign map_blk  = map_rzero_q ? '0 : map_rdata_q;
  assign cur_size = size_q[cmd_q.file_index];
  assign m_idx    = {cmd_q.file_index, cmd_q.entry};
  assign k_idx    = {cmd_q.file_index, k_q};
  assign tgt_idx  = (cmd_q.kind == CMD_CREATE) ? {slot_q, ENTRY_W'(0)} : m_idx;
  assign off_len  = LEN_W'(cmd_q.offset) + LEN_W'(1);
  assign new_len  = (off_len > cur_size) ? off_len : cur_size;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    slot_d      = slot_q;
    blk_d       = blk_q;
    clr_d       = clr_q;
    k_d         = k_q;
    cmd_pop_o   = 1'b0;
    map_we      = 1'b0;
    map_waddr   = tgt_idx;
    map_raddr   = m_idx;
    store_we    = 1'b0;
    store_waddr = {blk_q, clr_q};
    store_wdata = '0;
    store_raddr = {map_blk, cmd_q.byte_sel};
    in_use_set  = 1'b0;
    in_use_clr  = 1'b0;
    in_use_idx  = cmd_q.file_index;
    size_we     = 1'b0;
    size_idx    = cmd_q.file_index;
    size_wdata  = '0;
    busy_set    = 1'b0;
    busy_clr    = 1'b0;
    busy_idx    = blk_q;
    mv_set      = 1'b0;
    mv_clr      = 1'b0;
    mv_idx      = tgt_idx;
    res_push    = 1'b0;
    res_d       = '{status: ST_OK, rbyte: '0, slot: cmd_q.file_index, len: cur_size};

    unique case (state_q) inside
      S_IDLE: begin
        // Start only with room for the result, so it can always be pushed.
        if (cmd_valid_i && rq_cnt_q != 2'd2) begin
          cmd_pop_o = 1'b1;
          cmd_d     = cmd_i;
          state_d   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (cmd_q.kind == CMD_CREATE) begin
          slot_d  = SLOT_W'(1);
          state_d = S_SLOTSCAN;
        end else if (cmd_q.kind == CMD_BAD || !in_use_q[cmd_q.file_index]) begin
          res_d.status = ST_BADFILE;
          res_d.len    = '0;
          res_push     = 1'b1;
          state_d      = S_IDLE;
        end else begin
          case (cmd_q.kind) inside
            CMD_WRITE: begin
              if (cmd_q.entry_over) begin
                res_d.status = ST_NOSPACE;
                res_push     = 1'b1;
                state_d      = S_IDLE;
              end else if (!mv_q[m_idx]) begin
                blk_d   = '0;
                state_d = S_BLKSCAN;
              end else begin
                state_d = S_MAPUSE;
              end
            end
            CMD_READ: begin
              if (cmd_q.offset >= OFF_W'(cur_size) || cmd_q.entry_over) begin
                res_d.status = ST_EOF;
                res_push     = 1'b1;
                state_d      = S_IDLE;
              end else if (!mv_q[m_idx]) begin
                res_d.status = ST_UNMAPPED;
                res_push     = 1'b1;
                state_d      = S_IDLE;
              end else begin
                state_d = S_MAPUSE;
              end
            end
            CMD_TRUNC, CMD_DELETE: begin
              if (cmd_q.file_index == '0) begin
                res_d.status = ST_BADFILE;
                res_d.len    = '0;
                res_push     = 1'b1;
                state_d      = S_IDLE;
              end else begin
                k_d     = '0;
                state_d = S_DROP;
              end
            end
            default: begin
              res_push = 1'b1;
              state_d  = S_IDLE;
            end
          endcase
        end
      end
      S_MAPUSE: begin
        if (cmd_q.kind == CMD_WRITE) begin
          store_we    = 1'b1;
          store_waddr = {map_blk, cmd_q.byte_sel};
          store_wdata = cmd_q.data;
          size_we     = 1'b1;
          size_wdata  = new_len;
          res_d.len   = new_len;
          res_push    = 1'b1;
          state_d     = S_IDLE;
        end else begin
          state_d = S_RDWAIT;
        end
      end
      S_RDWAIT: begin
        res_d.rbyte = store_rdata_q;
        res_push    = 1'b1;
        state_d     = S_IDLE;
      end
      S_SLOTSCAN: begin
        if (!in_use_q[slot_q]) begin
          in_use_set = 1'b1;
          in_use_idx = slot_q;
          size_we    = 1'b1;
          size_idx   = slot_q;
          blk_d      = '0;
          state_d    = S_BLKSCAN;
        end else if (slot_q == SLOT_W'(FILE_SLOTS - 1)) begin
          res_d.status = ST_NOSLOT;
          res_d.slot   = '0;
          res_d.len    = '0;
          res_push     = 1'b1;
          state_d      = S_IDLE;
        end else begin
          slot_d = slot_q + SLOT_W'(1);
        end
      end
      S_BLKSCAN: begin
        if (!busy_q[blk_q]) begin
          busy_set = 1'b1;
          clr_d    = '0;
          state_d  = S_CLEAR;
        end else if (blk_q == BLK_W'(POOL_BLOCKS - 1)) begin
          // Pool exhausted: a create still succeeds with an empty map.
          if (cmd_q.kind == CMD_CREATE) begin
            res_d.slot = slot_q;
            res_d.len  = '0;
          end else begin
            res_d.status = ST_NOSPACE;
          end
          res_push = 1'b1;
          state_d  = S_IDLE;
        end else begin
          blk_d = blk_q + BLK_W'(1);
        end
      end
      S_CLEAR: begin
        store_we = 1'b1;
        if (clr_q == WITHIN_W'(BLOCK_BYTES - 1)) begin
          map_we = 1'b1;
          mv_set = 1'b1;
          if (cmd_q.kind == CMD_CREATE) begin
            res_d.slot = slot_q;
            res_d.len  = '0;
            res_push   = 1'b1;
            state_d    = S_IDLE;
          end else begin
            state_d = S_WRBYTE;
          end
        end else begin
          clr_d = clr_q + WITHIN_W'(1);
        end
      end
      S_WRBYTE: begin
        store_we    = 1'b1;
        store_waddr = {blk_q, cmd_q.byte_sel};
        store_wdata = cmd_q.data;
        size_we     = 1'b1;
        size_wdata  = new_len;
        res_d.len   = new_len;
        res_push    = 1'b1;
        state_d     = S_IDLE;
      end
      S_DROP, S_FREE: begin
        map_raddr = k_idx;
        mv_idx    = k_idx;
        busy_idx  = map_blk;
        if (state_q == S_DROP && mv_q[k_idx]) begin
          state_d = S_FREE;
        end else begin
          if (state_q == S_FREE) begin
            busy_clr = 1'b1;
            mv_clr   = 1'b1;
            state_d  = S_DROP;
          end
          if (k_q == ENTRY_W'(BLOCKS_PER_FILE - 1)) begin
            size_we    = 1'b1;
            in_use_clr = (cmd_q.kind == CMD_DELETE);
            res_d.len  = '0;
            res_push   = 1'b1;
            state_d    = S_IDLE;
          end else begin
            k_d = k_q + ENTRY_W'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_waddr] <= blk_q;
    end
    map_rdata_q <= map_mem[map_raddr];
    map_rzero_q <= (map_raddr == '0);
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[store_waddr] <= store_wdata;
    end
    store_rdata_q <= store_mem[store_raddr];
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    slot_q <= slot_d;
    blk_q  <= blk_d;
    clr_q  <= clr_d;
    k_q    <= k_d;
    if (res_push) begin
      rq_mem[rq_wr_q] <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      in_use_q <= FILE_SLOTS'(1);
      mv_q     <= MAP_DEPTH'(1);
      busy_q   <= POOL_BLOCKS'(1);
      for (int i = 0; i < FILE_SLOTS; i++) begin
        size_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (in_use_set) in_use_q[in_use_idx] <= 1'b1;
      if (in_use_clr) in_use_q[in_use_idx] <= 1'b0;
      if (size_we) size_q[size_idx] <= size_wdata;
      if (busy_set) busy_q[busy_idx] <= 1'b1;
      if (busy_clr) busy_q[busy_idx] <= 1'b0;
      if (mv_set) mv_q[mv_idx] <= 1'b1;
      if (mv_clr) mv_q[mv_idx] <= 1'b0;
    end
  end

  assign empty  = (rq_cnt_q == 2'd0);
  assign res_o  = rq_mem[rq_rd_q];
  assign rq_pop = pop && !empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rq_wr_q  <= 1'b0;
      rq_rd_q  <= 1'b0;
      rq_cnt_q <= 2'd0;
    end else begin
      if (res_push) rq_wr_q <= !rq_wr_q;
      if (rq_pop) rq_rd_q <= !rq_rd_q;
      rq_cnt_q <= rq_cnt_q + 2'(res_push) - 2'(rq_pop);
    end
  end

endmodule

// ===== rtl/block_mapped_file_store.sv =====
// Top level of the block-mapped file store: front decoder, back end and checks.
//
// Each transaction runs one file operation and yields one result. The back end
// handles one operation at a time. A write to an unmapped block and a create
// walk the block bitmap one block a cycle and then zero the new block one byte a
// cycle through the byte store's write port; a create first walks the slot table
// one slot a cycle (slots 1 to 31). Truncate and delete walk the file's map
// entries in turn and free each mapped block. A two-entry queue on each side
// lets new operations and finished results wait.
module block_mapped_file_store import bmfs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [OP_W-1:0]      opcode_i,
  input  logic [SLOT_W-1:0]    file_index_i,
  input  logic [OFF_W-1:0]     offset_i,
  input  logic [DATA_W-1:0]    data_byte_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [STATUS_W-1:0]  status_o,
  output logic [DATA_W-1:0]    read_byte_o,
  output logic [SLOT_W-1:0]    slot_out_o,
  output logic [LEN_W-1:0]     file_length_o
);

  cmd_t cmd;
  logic cmd_valid, cmd_pop;
  res_t res;

  bmfs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .opcode_i    (opcode_i),
    .file_index_i(file_index_i),
    .offset_i    (offset_i),
    .data_byte_i (data_byte_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  bmfs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_valid_i(cmd_valid),
    .cmd_pop_o  (cmd_pop),
    .res_o      (res),
    .empty      (empty),
    .pop        (pop)
  );

  assign status_o      = res.status;
  assign read_byte_o   = res.rbyte;
  assign slot_out_o    = res.slot;
  assign file_length_o = res.len;

  a_rbyte_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && read_byte_o != '0) |-> status_o == ST_OK)
    else $error("read byte is nonzero on a failed operation");

  a_noslot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == ST_NOSLOT) |-> (slot_out_o == '0 && file_length_o == '0))
    else $error("no-slot result carries a slot or a length");

  a_badfile_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && status_o == ST_BADFILE) |-> file_length_o == '0)
    else $error("bad-file result carries a length");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> file_length_o <= LEN_W'(BLOCKS_PER_FILE * BLOCK_BYTES))
    else $error("file length beyond the direct map");

endmodule
